// File: src/dmn_pkg.sv
// Shared types and constants for the distributed mutex node.
// Used by dmn_peer_check, dmn_ctrl and distributed_mutex_node_top; no dependencies.
package dmn_pkg;

  // Group and field sizing
  localparam int unsigned MaxNodes = 16;
  localparam int unsigned NodeW    = 4;
  localparam int unsigned SeqW     = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned RunW     = 4;

  // Configuration register indexes
  localparam logic CFG_OWN_NODE_ID = 1'b0;
  localparam logic CFG_NODE_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    REQ_PEER_REQUEST = 2'd0,
    REQ_PEER_REPLY   = 2'd1,
    REQ_ENTER        = 2'd2,
    REQ_RELEASE      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    MSG_REQ   = 2'd0,
    MSG_RPL   = 2'd1,
    MSG_GRANT = 2'd2
  } msg_kind_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NodeW-1:0] peer_node;
    logic [SeqW-1:0]  peer_sequence;
  } req_t;

  typedef struct packed {
    logic [1:0]       message_kind;
    logic [NodeW-1:0] dest_node;
    logic [SeqW-1:0]  message_sequence;
    logic             last_of_run;
  } res_t;

  // Group view handed to the membership checker
  typedef struct packed {
    logic [NodeW-1:0]  own_id;
    logic [CountW-1:0] peer_count;
  } grp_t;

endpackage

// File: src/distributed_mutex_node_top.sv
// Distributed mutex node: one node of a Ricart-Agrawala mutual exclusion group.
//
// Usage:
//   Events enter on req_i when start_i is high and busy_o is low: a peer
//   request, a peer reply, a local enter wish or a local release.
//   Outgoing messages leave on result_o, each valid for exactly one cycle
//   while result_valid_o is high; last_of_run marks the final one of an
//   event. The receiver cannot stall; every strobe is a transaction.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 own node
//   id, 1 node count). Write only while busy_o is low and no message is due.
// Sequencing and throughput:
//   A peer request or reply is handled in the idle state; its message, if
//   any, shows in the next cycle and busy_o stays low. An enter wish (taken
//   only when not requesting) or a release walks all 16 node ids through
//   the shared membership comparator, one per cycle, then drains the held
//   message, or grants at once when there are no peers; busy_o is high for
//   the walk and the drain. Messages leave at most one per cycle.
// Reset: clears all protocol state and deferred peers, own id 0, node
//   count 1. Depends on dmn_pkg, dmn_peer_check and dmn_ctrl.
module distributed_mutex_node_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dmn_pkg::req_t                 req_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dmn_pkg::CountW-1:0]    cfg_wdata_i,
  output logic                          result_valid_o,
  output dmn_pkg::res_t                 result_o
);

  dmn_pkg::grp_t              grp;
  logic [dmn_pkg::NodeW-1:0]  node_sel;
  logic                       is_peer;

  // Shared membership comparator
  dmn_peer_check u_peer_check (
    .grp_i     (grp),
    .node_i    (node_sel),
    .is_peer_o (is_peer)
  );

  // Sequencer and protocol state
  dmn_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .is_peer_i      (is_peer),
    .grp_o          (grp),
    .node_sel_o     (node_sel),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: src/dmn_peer_check.sv
// Shared membership comparator: tells whether a node id is a peer of the group.
// Depends on dmn_pkg.
module dmn_peer_check (
  input  dmn_pkg::grp_t                grp_i,
  input  logic [dmn_pkg::NodeW-1:0]    node_i,
  output logic                         is_peer_o
);

  logic [dmn_pkg::NodeW-1:0] rank;

  // Peers are ranked by id with the own id squeezed out
  always_comb begin
    rank = (node_i < grp_i.own_id) ? node_i : node_i - dmn_pkg::NodeW'(1);
    is_peer_o = (node_i != grp_i.own_id) &&
                ({1'b0, rank} < grp_i.peer_count);
  end

endmodule

// File: src/dmn_ctrl.sv
// Sequencer and protocol state of the mutex node: config registers, sequences,
// deferred peers and the result register. Depends on dmn_pkg; takes dmn_peer_check's result.
module dmn_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dmn_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dmn_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          is_peer_i,
  output dmn_pkg::grp_t                 grp_o,
  output logic [dmn_pkg::NodeW-1:0]     node_sel_o,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output dmn_pkg::res_t                 result_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  localparam logic [dmn_pkg::NodeW-1:0] LastIdx = dmn_pkg::NodeW'(dmn_pkg::MaxNodes - 1);
  localparam logic [dmn_pkg::RunW-1:0]  RunCap  = '1;
  localparam logic [dmn_pkg::SeqW-1:0]  SeqMax  = '1;

  state_e                        state_q, state_d;
  logic [dmn_pkg::NodeW-1:0]     own_id_q, own_id_d;
  logic [dmn_pkg::CountW-1:0]    node_count_q, node_count_d;
  logic [dmn_pkg::SeqW-1:0]      highest_q, highest_d;
  logic [dmn_pkg::SeqW-1:0]      own_seq_q, own_seq_d;
  logic                          requesting_q, requesting_d;
  logic [dmn_pkg::CountW-1:0]    outstanding_q, outstanding_d;
  logic [dmn_pkg::MaxNodes-1:0]  deferred_q, deferred_d;
  logic                          enter_mode_q, enter_mode_d;
  logic [dmn_pkg::NodeW-1:0]     idx_q, idx_d;
  logic [dmn_pkg::RunW-1:0]      run_cnt_q, run_cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  dmn_pkg::res_t                 pend_q, pend_d;
  logic                          res_valid_q, res_valid_d;
  dmn_pkg::res_t                 res_q, res_d;
  logic [dmn_pkg::CountW-1:0]    group_size;
  logic                          scan_hit;
  dmn_pkg::res_t                 scan_res;

  // Clamp the group size to 1..MaxNodes
  always_comb begin
    if (node_count_q == '0) begin
      group_size = dmn_pkg::CountW'(1);
    end else if (node_count_q > dmn_pkg::CountW'(dmn_pkg::MaxNodes)) begin
      group_size = dmn_pkg::CountW'(dmn_pkg::MaxNodes);
    end else begin
      group_size = node_count_q;
    end
  end

  assign grp_o.own_id     = own_id_q;
  assign grp_o.peer_count = group_size - dmn_pkg::CountW'(1);
  assign node_sel_o       = (state_q == ST_IDLE) ? req_i.peer_node : idx_q;
  assign busy_o           = (state_q != ST_IDLE);
  assign result_valid_o   = res_valid_q;
  assign result_o         = res_q;

  // Build the message for the current scan position
  always_comb begin
    scan_res.dest_node   = idx_q;
    scan_res.last_of_run = 1'b0;
    if (enter_mode_q) begin
      scan_res.message_kind     = dmn_pkg::MSG_REQ;
      scan_res.message_sequence = own_seq_q;
      scan_hit                  = is_peer_i;
    end else begin
      scan_res.message_kind     = dmn_pkg::MSG_RPL;
      scan_res.message_sequence = '0;
      scan_hit                  = deferred_q[idx_q] && (run_cnt_q != RunCap);
    end
  end

  // Next-state logic
  always_comb begin
    state_d       = state_q;
    own_id_d      = own_id_q;
    node_count_d  = node_count_q;
    highest_d     = highest_q;
    own_seq_d     = own_seq_q;
    requesting_d  = requesting_q;
    outstanding_d = outstanding_q;
    deferred_d    = deferred_q;
    enter_mode_d  = enter_mode_q;
    idx_d         = idx_q;
    run_cnt_d     = run_cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;

    // Configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmn_pkg::CFG_OWN_NODE_ID: own_id_d     = cfg_wdata_i[dmn_pkg::NodeW-1:0];
        dmn_pkg::CFG_NODE_COUNT:  node_count_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_i.req_type)
            dmn_pkg::REQ_PEER_REQUEST: begin
              if (is_peer_i) begin
                if (req_i.peer_sequence > highest_q) begin
                  highest_d = req_i.peer_sequence;
                end
                if (requesting_q &&
                    ((req_i.peer_sequence > own_seq_q) ||
                     ((req_i.peer_sequence == own_seq_q) &&
                      (req_i.peer_node > own_id_q)))) begin
                  deferred_d[req_i.peer_node] = 1'b1;
                end else begin
                  res_valid_d            = 1'b1;
                  res_d.message_kind     = dmn_pkg::MSG_RPL;
                  res_d.dest_node        = req_i.peer_node;
                  res_d.message_sequence = '0;
                  res_d.last_of_run      = 1'b1;
                end
              end
            end
            dmn_pkg::REQ_PEER_REPLY: begin
              if (is_peer_i && requesting_q && (outstanding_q != '0)) begin
                outstanding_d = outstanding_q - dmn_pkg::CountW'(1);
                if (outstanding_q == dmn_pkg::CountW'(1)) begin
                  res_valid_d            = 1'b1;
                  res_d.message_kind     = dmn_pkg::MSG_GRANT;
                  res_d.dest_node        = own_id_q;
                  res_d.message_sequence = '0;
                  res_d.last_of_run      = 1'b1;
                end
              end
            end
            dmn_pkg::REQ_ENTER: begin
              if (!requesting_q) begin
                requesting_d  = 1'b1;
                own_seq_d     = (highest_q == SeqMax) ? SeqMax
                                                      : highest_q + dmn_pkg::SeqW'(1);
                highest_d     = own_seq_d;
                outstanding_d = group_size - dmn_pkg::CountW'(1);
                enter_mode_d  = 1'b1;
                idx_d         = '0;
                run_cnt_d     = '0;
                pend_valid_d  = 1'b0;
                state_d       = ST_SCAN;
              end
            end
            dmn_pkg::REQ_RELEASE: begin
              requesting_d  = 1'b0;
              outstanding_d = '0;
              enter_mode_d  = 1'b0;
              idx_d         = '0;
              run_cnt_d     = '0;
              pend_valid_d  = 1'b0;
              state_d       = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      // Walk one id per cycle; hold one message back to know which is last
      ST_SCAN: begin
        if (!enter_mode_q) begin
          deferred_d[idx_q] = 1'b0;
        end
        if (scan_hit) begin
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = pend_q;
          end
          pend_valid_d = 1'b1;
          pend_d       = scan_res;
          run_cnt_d    = run_cnt_q + dmn_pkg::RunW'(1);
        end
        idx_d = idx_q + dmn_pkg::NodeW'(1);
        if (idx_q == LastIdx) begin
          state_d = ST_FLUSH;
        end
      end

      // Drain the held message, or grant at once when there are no peers
      ST_FLUSH: begin
        if (enter_mode_q && (outstanding_q == '0)) begin
          res_valid_d            = 1'b1;
          res_d.message_kind     = dmn_pkg::MSG_GRANT;
          res_d.dest_node        = own_id_q;
          res_d.message_sequence = '0;
          res_d.last_of_run      = 1'b1;
        end else if (pend_valid_q) begin
          res_valid_d       = 1'b1;
          res_d             = pend_q;
          res_d.last_of_run = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      own_id_q      <= '0;
      node_count_q  <= dmn_pkg::CountW'(1);
      highest_q     <= '0;
      own_seq_q     <= '0;
      requesting_q  <= 1'b0;
      outstanding_q <= '0;
      deferred_q    <= '0;
      enter_mode_q  <= 1'b0;
      idx_q         <= '0;
      run_cnt_q     <= '0;
      pend_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      own_id_q      <= own_id_d;
      node_count_q  <= node_count_d;
      highest_q     <= highest_d;
      own_seq_q     <= own_seq_d;
      requesting_q  <= requesting_d;
      outstanding_q <= outstanding_d;
      deferred_q    <= deferred_d;
      enter_mode_q  <= enter_mode_d;
      idx_q         <= idx_d;
      run_cnt_q     <= run_cnt_d;
      pend_valid_q  <= pend_valid_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // Replies can only be outstanding while requesting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !requesting_q |-> (outstanding_q == '0))
    else $error("replies outstanding while not requesting");

  // Messages that leave during the walk are never the last of the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && res_valid_q |-> !res_q.last_of_run)
    else $error("last_of_run flagged during the peer walk");

  // A fresh enter wish starts the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && start_i && (req_i.req_type == dmn_pkg::REQ_ENTER) &&
    !requesting_q |=> (state_q == ST_SCAN) && requesting_q)
    else $error("enter wish did not start the walk");

  // An enter wish while requesting produces nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && start_i && (req_i.req_type == dmn_pkg::REQ_ENTER) &&
    requesting_q |=> !res_valid_q && (state_q == ST_IDLE))
    else $error("repeated enter wish produced activity");

endmodule
